// ===== hdl/rke_pkg.sv =====
// ---------------------------------------------------------------------------
// Ripley K estimator package
// Widths, constants, codes, sequencer states and shared helpers.
// ---------------------------------------------------------------------------
package rke_pkg;

  localparam int MAX_POINTS_DEF  = 512;
  localparam int ANGLE_STEPS_DEF = 125;
  localparam int COORD_FRAC_BITS = 8;

  localparam int ACTION_W = 2;
  localparam int COORD_W  = 19;
  localparam int RADIUS_W = 16;
  localparam int BOX_W    = 11;
  localparam int K_W      = 32;
  localparam int STATUS_W = 2;
  localparam int BOXC_W   = BOX_W + COORD_FRAC_BITS;
  localparam int EXT_W    = COORD_W + 1;
  localparam int AX_W     = COORD_W + 2;
  localparam int OFS_W    = 18;
  localparam int MAG_W    = 17;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int TRIG_W = 32;
  localparam int DIV_W  = 64;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE     = 32'sd1073741824;
  localparam logic signed [MUL_W-1:0]  STEP_COS_Q30 = 33'sd1072399926;
  localparam logic signed [MUL_W-1:0]  STEP_SIN_Q30 = 33'sd53664724;
  localparam logic signed [MUL_W-1:0]  DISC_Q24     = 33'sd2108287141;

  localparam logic [BOX_W-1:0] BOX_WIDTH_RESET  = 11'd1388;
  localparam logic [BOX_W-1:0] BOX_HEIGHT_RESET = 11'd1040;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_SAT   = 2'd2;

  localparam logic REG_BOX_WIDTH  = 1'b0;
  localparam logic REG_BOX_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE, S_R2, S_INIT, S_PI_RD, S_PI_LAT,
    S_PJ_RD, S_PJ_DX, S_PJ_DY, S_PJ_CMP, S_PJ_DONE,
    S_W_C1, S_W_C2, S_W_C3, S_W_C4, S_W_C5,
    S_W_RC, S_W_RS, S_W_RSL, S_W_CLS, S_W_AN, S_W_AD, S_W_MD, S_W_ADD, S_W_NEXT,
    S_WT_SET, S_WT_MD, S_WT_DONE, S_ACC, S_NEXT_I,
    S_F_AREA, S_F_N2, S_F_MD, S_OUT,
    S_MD_P0, S_MD_P1, S_MD_P2, S_MD_P3, S_MD_P4, S_MD_DIV, S_MD_WAIT
  } rke_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } rke_div_sts_t;

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rs;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    rs  = (mag + (PROD_W'(1) << 29)) >> 30;
    return v[PROD_W-1] ? -$signed(rs[TRIG_W-1:0]) : $signed(rs[TRIG_W-1:0]);
  endfunction

endpackage

// ===== hdl/rke_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rke_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/rke_div.sv =====
// ---------------------------------------------------------------------------
// Restoring divider
// Divides a 128-bit product by a 64-bit divisor, one quotient bit a cycle,
// saturating when the quotient does not fit in 64 bits.
// ---------------------------------------------------------------------------
module rke_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [2*rke_pkg::DIV_W-1:0]    num,
  input  logic [rke_pkg::DIV_W-1:0]      den,
  output logic [rke_pkg::DIV_W-1:0]      quo,
  output rke_pkg::rke_div_sts_t          sts
);
  import rke_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] hi;
  logic [DIV_W-1:0] lo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   hi_sh;
  logic             ge;
  logic [DIV_W:0]   hi_sub;

  assign hi_sh  = {hi, lo[DIV_W-1]};
  assign ge     = hi_sh >= {1'b0, den};
  assign hi_sub = hi_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
      sts.sat  <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (start) begin
        if (den == '0 || num[2*DIV_W-1:DIV_W] >= den) begin
          sts.sat  <= 1'b1;
          sts.done <= 1'b1;
          quo      <= '1;
        end else begin
          sts.sat <= 1'b0;
          hi      <= num[2*DIV_W-1:DIV_W];
          lo      <= num[DIV_W-1:0];
          quo     <= '0;
          cnt     <= CW'(DIV_W - 1);
          busy    <= 1'b1;
        end
      end else if (busy) begin
        hi  <= ge ? hi_sub[DIV_W-1:0] : hi_sh[DIV_W-1:0];
        lo  <= {lo[DIV_W-2:0], 1'b0};
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/ripley_k_edge_corrected_core.sv =====
// A query scans the point RAM pair by pair; each point with neighbours whose disc
// reaches the box edge then walks the wedges (125 wedges), dividing for each
// clipped wedge, and divides once more for its weight; the final scaling also
// divides. The shared multiplier and the bit-serial divider serve every step,
// and one word is worked on at a time.
// Reset empties the point store (no clearing pass) and loads a 1388 by 1040 box.
// ---------------------------------------------------------------------------
// Edge-corrected Ripley K core
// Point store, pair counting and wedge-based edge correction on one shared
// multiplier and one divider under a small sequencer.
// ---------------------------------------------------------------------------
module ripley_k_edge_corrected_core #(
  parameter int MAX_POINTS  = rke_pkg::MAX_POINTS_DEF,
  parameter int ANGLE_STEPS = rke_pkg::ANGLE_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // action[1:0], pos_x[20:2], pos_y[39:21], radius[55:40]
  input  logic [rke_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // k_value[31:0], status[33:32], zero fill above
  output logic [rke_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rke_pkg::APB_AW-1:0]    paddr,
  input  logic [rke_pkg::APB_DW-1:0]    pwdata,
  output logic [rke_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import rke_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int KI_W  = $clog2(ANGLE_STEPS);
  localparam int DSUM_W = 32 + $clog2(ANGLE_STEPS + 1);

  rke_state_t state, state_next, md_ret;

  logic [BOX_W-1:0]    box_width, box_height;
  logic [CNT_W-1:0]    point_count, n, i, j, others;
  logic [RADIUS_W-1:0] r;
  logic [31:0]         r2;
  logic [COORD_W-1:0]  x0, y0;
  logic signed [EXT_W-1:0] dy;
  logic [2*EXT_W-1:0]  sq;
  logic signed [TRIG_W-1:0] c, s, nc;
  logic signed [PROD_W-1:0] tmp;
  logic signed [OFS_W-1:0]  rc, rs;
  logic [MAG_W-1:0]    an, ad;
  logic [2*MAG_W-1:0]  an2;
  logic [DSUM_W-1:0]   dsum;
  logic [KI_W-1:0]     k;
  logic [DIV_W-1:0]    wt, sum, md_a, md_b, md_c;
  logic [2*DIV_W-1:0]  acc;
  logic [2*BOX_W-1:0]  area;
  logic                sat, empty;
  logic [K_W-1:0]      k_out;
  logic [STATUS_W-1:0] sts_out;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [2*COORD_W-1:0] rd_data;
  logic                 div_start;
  logic [DIV_W-1:0]     div_q;
  rke_div_sts_t         div_sts;

  logic                 in_acc;
  logic [ACTION_W-1:0]  in_action;
  logic [COORD_W-1:0]   in_x, in_y;
  logic [RADIUS_W-1:0]  in_r;
  logic [COORD_W-1:0]   rd_x, rd_y;
  logic signed [EXT_W-1:0] dx_c, dy_c;
  logic [BOXC_W-1:0]    wb, hb;
  logic signed [AX_W-1:0] ax, ay, wx, hy, x0e, y0e, rce, rse, num, den;
  logic [AX_W-1:0]      an_c, ad_c;
  logic                 rim_in_box, full_wedge, interior, out_free;
  logic [DIV_W:0]       sum_add;
  logic                 big;

  assign in_acc    = s_tvalid && s_tready;
  assign in_action = s_tdata[1:0];
  assign in_x      = s_tdata[20:2];
  assign in_y      = s_tdata[39:21];
  assign in_r      = s_tdata[55:40];
  assign rd_x      = rd_data[COORD_W-1:0];
  assign rd_y      = rd_data[2*COORD_W-1:COORD_W];
  assign out_free  = !m_tvalid || m_tready;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOX_HEIGHT) ? APB_DW'(box_height) : APB_DW'(box_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= BOX_WIDTH_RESET;
      box_height <= BOX_HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BOX_WIDTH) begin
        box_width <= pwdata[BOX_W-1:0];
      end else begin
        box_height <= pwdata[BOX_W-1:0];
      end
    end
  end

  rke_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_points (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[AW-1:0]),
    .wr_data ({in_y, in_x}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rke_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (md_c),
    .quo   (div_q),
    .sts   (div_sts)
  );

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Geometry of the current wedge and of the current point.
  assign dx_c = $signed({1'b0, x0}) - $signed({1'b0, rd_x});
  assign dy_c = $signed({1'b0, y0}) - $signed({1'b0, rd_y});
  assign wb   = {box_width, COORD_FRAC_BITS'(0)};
  assign hb   = {box_height, COORD_FRAC_BITS'(0)};
  assign x0e  = $signed(AX_W'(x0));
  assign y0e  = $signed(AX_W'(y0));
  assign wx   = $signed(AX_W'(wb));
  assign hy   = $signed(AX_W'(hb));
  assign rce  = AX_W'(rc);
  assign rse  = AX_W'(rs);
  assign ax   = x0e + rce;
  assign ay   = y0e + rse;
  assign rim_in_box = !ax[AX_W-1] && (ax <= wx) && !ay[AX_W-1] && (ay <= hy);

  // Left and right edges take precedence over bottom and top.
  always_comb begin
    if (ax[AX_W-1]) begin
      num = x0e;
      den = -rce;
    end else if (ax > wx) begin
      num = wx - x0e;
      den = rce;
    end else if (ay[AX_W-1]) begin
      num = y0e;
      den = -rse;
    end else begin
      num = hy - y0e;
      den = rse;
    end
  end

  assign an_c = num[AX_W-1] ? AX_W'(-num) : AX_W'(num);
  assign ad_c = den[AX_W-1] ? AX_W'(-den) : AX_W'(den);
  assign full_wedge = rim_in_box || (ad_c == '0) || (an_c >= ad_c);

  assign interior = ({4'd0, r} < {1'b0, x0}) && ({4'd0, r} < {1'b0, y0})
                 && (({4'd0, r} + {1'b0, x0}) < {1'b0, wb})
                 && (({4'd0, r} + {1'b0, y0}) < {1'b0, hb});

  assign sum_add = {1'b0, sum} + {1'b0, wt};
  assign big     = div_sts.sat || (div_q[DIV_W-1:K_W] != '0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && in_action == ACT_QUERY) begin
          state_next = (point_count == '0) ? S_OUT : S_R2;
        end
      end
      S_R2:      state_next = S_INIT;
      S_INIT:    state_next = (r == '0) ? S_F_AREA : S_PI_RD;
      S_PI_RD:   state_next = S_PI_LAT;
      S_PI_LAT:  state_next = S_PJ_RD;
      S_PJ_RD: begin
        if (j == n) begin
          state_next = S_PJ_DONE;
        end else if (j != i) begin
          state_next = S_PJ_DX;
        end
      end
      S_PJ_DX:   state_next = S_PJ_DY;
      S_PJ_DY:   state_next = S_PJ_CMP;
      S_PJ_CMP:  state_next = S_PJ_RD;
      S_PJ_DONE: begin
        if (others == '0) begin
          state_next = S_NEXT_I;
        end else if (interior) begin
          state_next = S_ACC;
        end else begin
          state_next = S_W_C1;
        end
      end
      S_W_C1:    state_next = S_W_C2;
      S_W_C2:    state_next = S_W_C3;
      S_W_C3:    state_next = S_W_C4;
      S_W_C4:    state_next = S_W_C5;
      S_W_C5:    state_next = S_W_RC;
      S_W_RC:    state_next = S_W_RS;
      S_W_RS:    state_next = S_W_RSL;
      S_W_RSL:   state_next = S_W_CLS;
      S_W_CLS:   state_next = full_wedge ? S_W_NEXT : S_W_AN;
      S_W_AN:    state_next = S_W_AD;
      S_W_AD:    state_next = S_W_MD;
      S_W_MD:    state_next = S_MD_P0;
      S_W_ADD:   state_next = S_W_NEXT;
      S_W_NEXT:  state_next = (k == KI_W'(ANGLE_STEPS - 1)) ? S_WT_SET : S_W_C1;
      S_WT_SET:  state_next = (dsum == '0) ? S_ACC : S_WT_MD;
      S_WT_MD:   state_next = S_MD_P0;
      S_WT_DONE: state_next = S_ACC;
      S_ACC:     state_next = S_NEXT_I;
      S_NEXT_I:  state_next = ((i + 1'b1) == n) ? S_F_AREA : S_PI_RD;
      S_F_AREA:  state_next = S_F_N2;
      S_F_N2:    state_next = S_F_MD;
      S_F_MD:    state_next = S_MD_P0;
      S_OUT:     state_next = out_free ? S_IDLE : S_OUT;
      S_MD_P0:   state_next = S_MD_P1;
      S_MD_P1:   state_next = S_MD_P2;
      S_MD_P2:   state_next = S_MD_P3;
      S_MD_P3:   state_next = S_MD_P4;
      S_MD_P4:   state_next = S_MD_DIV;
      S_MD_DIV:  state_next = S_MD_WAIT;
      S_MD_WAIT: state_next = div_sts.done ? md_ret : S_MD_WAIT;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control outputs and multiplier operands.
  always_comb begin
    s_tready  = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    rd_addr   = j[AW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        wr_en    = in_acc && (in_action == ACT_LOAD) && (point_count < CNT_W'(MAX_POINTS));
      end
      S_R2:     begin mul_a = MUL_W'(r);      mul_b = MUL_W'(r);      end
      S_PI_RD:  rd_addr = i[AW-1:0];
      S_PJ_DX:  begin mul_a = MUL_W'(dx_c);   mul_b = MUL_W'(dx_c);   end
      S_PJ_DY:  begin mul_a = MUL_W'(dy);     mul_b = MUL_W'(dy);     end
      S_W_C1:   begin mul_a = MUL_W'(c);      mul_b = STEP_COS_Q30;   end
      S_W_C2:   begin mul_a = MUL_W'(s);      mul_b = STEP_SIN_Q30;   end
      S_W_C3:   begin mul_a = MUL_W'(s);      mul_b = STEP_COS_Q30;   end
      S_W_C4:   begin mul_a = MUL_W'(c);      mul_b = STEP_SIN_Q30;   end
      S_W_RC:   begin mul_a = MUL_W'(r);      mul_b = MUL_W'(c);      end
      S_W_RS:   begin mul_a = MUL_W'(r);      mul_b = MUL_W'(s);      end
      S_W_AN:   begin mul_a = MUL_W'(an);     mul_b = MUL_W'(an);     end
      S_W_AD:   begin mul_a = MUL_W'(ad);     mul_b = MUL_W'(ad);     end
      S_WT_SET: begin mul_a = MUL_W'(others); mul_b = DISC_Q24;       end
      S_F_AREA: begin mul_a = MUL_W'(box_width); mul_b = MUL_W'(box_height); end
      S_F_N2:   begin mul_a = MUL_W'(n);      mul_b = MUL_W'(n);      end
      S_MD_P0:  begin mul_a = MUL_W'(md_a[31:0]);  mul_b = MUL_W'(md_b[31:0]);  end
      S_MD_P1:  begin mul_a = MUL_W'(md_a[31:0]);  mul_b = MUL_W'(md_b[63:32]); end
      S_MD_P2:  begin mul_a = MUL_W'(md_a[63:32]); mul_b = MUL_W'(md_b[31:0]);  end
      S_MD_P3:  begin mul_a = MUL_W'(md_a[63:32]); mul_b = MUL_W'(md_b[63:32]); end
      S_MD_DIV: div_start = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Point count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (wr_en) begin
        point_count <= point_count + 1'b1;
      end else if (in_acc && in_action == ACT_CLEAR) begin
        point_count <= '0;
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n     <= point_count;
        r     <= in_r;
        empty <= (point_count == '0);
        sum   <= '0;
        sat   <= 1'b0;
        i     <= '0;
      end
      S_INIT:   r2 <= mul_p[31:0];
      S_PI_LAT: begin
        x0     <= rd_x;
        y0     <= rd_y;
        j      <= '0;
        others <= '0;
      end
      S_PJ_RD: begin
        if (j != n && j == i) begin
          j <= j + 1'b1;
        end
      end
      S_PJ_DX:  dy <= dy_c;
      S_PJ_DY:  sq <= mul_p[2*EXT_W-1:0];
      S_PJ_CMP: begin
        if ((({1'b0, sq}) + mul_p[2*EXT_W:0]) <= (2*EXT_W+1)'(r2)) begin
          others <= others + 1'b1;
        end
        j <= j + 1'b1;
      end
      S_PJ_DONE: begin
        wt   <= DIV_W'(others) << 24;
        c    <= TRIG_ONE;
        s    <= '0;
        k    <= '0;
        dsum <= '0;
      end
      S_W_C2:  tmp <= mul_p;
      S_W_C3:  nc  <= rnd30(tmp - mul_p);
      S_W_C4:  tmp <= mul_p;
      S_W_C5: begin
        s <= rnd30(tmp + mul_p);
        c <= nc;
      end
      S_W_RS:  rc <= OFS_W'(rnd30(mul_p));
      S_W_RSL: rs <= OFS_W'(rnd30(mul_p));
      S_W_CLS: begin
        if (full_wedge) begin
          dsum <= dsum + DSUM_W'(r2);
        end
        an <= an_c[MAG_W-1:0];
        ad <= ad_c[MAG_W-1:0];
      end
      S_W_AD: an2 <= mul_p[2*MAG_W-1:0];
      S_W_MD: begin
        md_a   <= DIV_W'(r2);
        md_b   <= DIV_W'(an2);
        md_c   <= mul_p[DIV_W-1:0];
        md_ret <= S_W_ADD;
      end
      S_W_ADD:  dsum <= dsum + div_q[DSUM_W-1:0];
      S_W_NEXT: k <= k + 1'b1;
      S_WT_SET: begin
        if (dsum == '0) begin
          wt <= '0;
        end
      end
      S_WT_MD: begin
        md_a   <= mul_p[DIV_W-1:0];
        md_b   <= DIV_W'(r2);
        md_c   <= DIV_W'(dsum);
        md_ret <= S_WT_DONE;
      end
      S_WT_DONE: wt <= div_q;
      S_ACC: begin
        // A saturated weight or a carry out of the running sum pins K high.
        if (wt == '1 || sum_add[DIV_W]) begin
          sat <= 1'b1;
        end
        sum <= sum_add[DIV_W] ? '1 : sum_add[DIV_W-1:0];
      end
      S_NEXT_I: i <= i + 1'b1;
      S_F_N2:   area <= mul_p[2*BOX_W-1:0];
      S_F_MD: begin
        md_a   <= sum;
        md_b   <= DIV_W'(area);
        md_c   <= DIV_W'(mul_p[2*CNT_W-1:0]) << (24 - COORD_FRAC_BITS);
        md_ret <= S_OUT;
      end
      S_MD_P1: acc <= (2*DIV_W)'(mul_p[63:0]);
      S_MD_P2: acc <= acc + ((2*DIV_W)'(mul_p[63:0]) << 32);
      S_MD_P3: acc <= acc + ((2*DIV_W)'(mul_p[63:0]) << 32);
      S_MD_P4: acc <= acc + ((2*DIV_W)'(mul_p[63:0]) << 64);
      S_OUT: begin
        if (out_free) begin
          if (empty) begin
            k_out   <= '0;
            sts_out <= STS_EMPTY;
          end else if (area == '0 || sum == '0) begin
            k_out   <= '0;
            sts_out <= STS_OK;
          end else if (sat || big) begin
            k_out   <= '1;
            sts_out <= STS_SAT;
          end else begin
            k_out   <= div_q[K_W-1:0];
            sts_out <= STS_OK;
          end
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign m_tdata = {(M_TDATA_W - K_W - STATUS_W)'(0), sts_out, k_out};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (sts_out == STS_OK || sts_out == STS_EMPTY || sts_out == STS_SAT))
    else $error("undefined status code");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sts_out == STS_EMPTY) |-> (k_out == '0))
    else $error("empty store result carries a value");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input taken during a query");

endmodule
